// ===== src/muscl_pkg.sv =====
package muscl_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DATA_W      = 32;
  localparam int EPS_W       = 32;

  localparam logic [EPS_W-1:0] EPS_RESET = 32'd4295;

  localparam int DIFF_W = DATA_W + 1;
  localparam int CMP_W  = (DIFF_W > VALUE_WIDTH ? DIFF_W : VALUE_WIDTH) + 1;

  localparam logic signed [CMP_W-1:0] D_MAX =
    signed'((CMP_W'(1) << (VALUE_WIDTH - 1)) - CMP_W'(1));
  localparam logic signed [CMP_W-1:0] D_MIN = ~D_MAX;

  localparam int PROD_W = 2 * VALUE_WIDTH;
  localparam int NUM_W  = PROD_W + 2;
  localparam int REM_W  = NUM_W + 1;

  localparam int FRAC_BITS = 30;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int DIV_STEPS = Q_W;

  localparam logic [Q_W-1:0] ONE_Q30 = Q_W'(1) << FRAC_BITS;

  localparam int RECIP_W      = 32;
  localparam int RECIP_PROD_W = Q_W + RECIP_W;
  localparam int RECIP_SHIFT  = 33;
  localparam logic [RECIP_W-1:0] RECIP3 = 32'hAAAA_AAAB;

  localparam int SCALE_W     = VALUE_WIDTH + Q_W;
  localparam int TERM_W      = SCALE_W - FRAC_BITS;
  localparam int MID_W       = TERM_W + 2;
  localparam int CORR_PROD_W = MID_W + Q_W;
  localparam int CORR_SHIFT  = 32;
  localparam int CORR_W      = CORR_PROD_W - CORR_SHIFT;
  localparam int RES_W       = (CORR_W > DATA_W ? CORR_W : DATA_W) + 2;

  localparam logic signed [RES_W-1:0] RES_MAX =
    signed'((RES_W'(1) << (DATA_W - 1)) - RES_W'(1));
  localparam logic signed [RES_W-1:0] RES_MIN = ~RES_MAX;

  typedef struct packed {
    logic                          side;
    logic signed [DATA_W-1:0]      centre;
    logic signed [VALUE_WIDTH-1:0] d1;
    logic signed [VALUE_WIDTH-1:0] d2;
    logic                          sat;
  } stencil_t;

  function automatic logic [VALUE_WIDTH-1:0] mag_value(
    input logic signed [VALUE_WIDTH-1:0] x
  );
    mag_value = x[VALUE_WIDTH-1] ? VALUE_WIDTH'(-x) : VALUE_WIDTH'(x);
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] clip_diff(
    input logic signed [CMP_W-1:0] x
  );
    if (x > D_MAX) begin
      clip_diff = D_MAX[VALUE_WIDTH-1:0];
    end else if (x < D_MIN) begin
      clip_diff = D_MIN[VALUE_WIDTH-1:0];
    end else begin
      clip_diff = x[VALUE_WIDTH-1:0];
    end
  endfunction

endpackage

// ===== src/muscl_limited_face_reconstruction.sv =====
// Third-order MUSCL face reconstruction with a van Albada limiter.
// Request channel: request_valid / request_stall carry face_side and the
// three Q16.16 stencil values; a request is taken at a rising edge with
// request_valid high and request_stall low.
// Result channel: result_valid / result_stall carry face_value (Q16.16,
// saturated) and the saturated flag.
// Throughput: one request per clock while result_stall does not hold the
// pipeline. A request passes from the accepting edge to result_valid
// through 40 register stages: the 31-stage restoring divider that forms
// the Q1.30 smoothness factor, one quotient bit per stage, plus nine
// stages of differences, products, divider load, the divide by three, the
// weighted slopes, the correction product and the saturated output.
// Epsilon is written through epsilon_write / epsilon_data; the user must do so
// only with no request in flight (not enforced by the block); reset loads 4295
// (about 1e-6 in Q32.32). Reset empties the pipeline and drops result_valid.
// While result_valid is high and result_stall is high, the whole pipeline
// holds and request_stall rises in the same cycle; nothing is lost or repeated.
module muscl_limited_face_reconstruction (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        epsilon_write,
  input  logic [muscl_pkg::EPS_W-1:0]                 epsilon_data,
  input  logic                                        request_valid,
  output logic                                        request_stall,
  input  logic                                        face_side,
  input  logic signed [muscl_pkg::DATA_W-1:0]         left_value,
  input  logic signed [muscl_pkg::DATA_W-1:0]         centre_value,
  input  logic signed [muscl_pkg::DATA_W-1:0]         right_value,
  output logic                                        result_valid,
  input  logic                                        result_stall,
  output logic signed [muscl_pkg::DATA_W-1:0]         face_value,
  output logic                                        saturated
);

  localparam int VW = muscl_pkg::VALUE_WIDTH;
  localparam int DS = muscl_pkg::DIV_STEPS;

  logic advance;
  logic [muscl_pkg::EPS_W-1:0] epsilon;

  logic signed [muscl_pkg::CMP_W-1:0] diff1_raw, diff2_raw;
  muscl_pkg::stencil_t diff_next;

  logic                diff_valid;
  muscl_pkg::stencil_t diff_st;

  logic [VW-1:0] m1, m2;

  logic                             prod_valid;
  muscl_pkg::stencil_t              prod_st;
  logic [muscl_pkg::PROD_W-1:0]     prod_12, prod_11, prod_22;
  logic                             prod_neg;

  logic [muscl_pkg::NUM_W-1:0] two_p, eps_ext, num_next, den_next;
  logic                        num_neg_next;

  logic                        div_valid [0:DS];
  muscl_pkg::stencil_t         div_st    [0:DS];
  logic [muscl_pkg::REM_W-1:0] div_rem   [0:DS];
  logic [muscl_pkg::NUM_W-1:0] div_den   [0:DS];
  logic [muscl_pkg::Q_W-1:0]   div_q     [0:DS];
  logic                        div_neg   [0:DS];
  logic                        div_zero  [0:DS];

  logic [muscl_pkg::REM_W-1:0] div_trial    [0:DS-1];
  logic                        div_ge       [0:DS-1];
  logic [muscl_pkg::REM_W-1:0] div_rem_next [0:DS-1];
  logic [muscl_pkg::Q_W-1:0]   div_q_next   [0:DS-1];

  logic [muscl_pkg::Q_W-1:0] smag_next;

  logic                               recip_valid;
  muscl_pkg::stencil_t                recip_st;
  logic [muscl_pkg::RECIP_PROD_W-1:0] recip_prod;
  logic [muscl_pkg::Q_W-1:0]          recip_smag;
  logic                               recip_sneg;

  logic [muscl_pkg::Q_W-1:0] tmag;

  logic                      coef_valid;
  muscl_pkg::stencil_t       coef_st;
  logic [muscl_pkg::Q_W-1:0] coef_a, coef_b;
  logic [muscl_pkg::Q_W-1:0] coef_smag;
  logic                      coef_sneg;

  logic signed [VW-1:0] slope_p, slope_q;

  logic                          scale_valid;
  muscl_pkg::stencil_t           scale_st;
  logic [muscl_pkg::SCALE_W-1:0] scale_pa, scale_qb;
  logic                          scale_pa_neg, scale_qb_neg;
  logic [muscl_pkg::Q_W-1:0]     scale_smag;
  logic                          scale_sneg;

  logic [muscl_pkg::TERM_W-1:0]       term_a_mag, term_b_mag;
  logic signed [muscl_pkg::MID_W-1:0] term_a_abs, term_b_abs, term_a, term_b;

  logic                               mid_valid;
  muscl_pkg::stencil_t                mid_st;
  logic signed [muscl_pkg::MID_W-1:0] mid_m;
  logic [muscl_pkg::Q_W-1:0]          mid_smag;
  logic                               mid_sneg;

  logic [muscl_pkg::MID_W-1:0] mid_mag;

  logic                              corr_valid;
  muscl_pkg::stencil_t               corr_st;
  logic [muscl_pkg::CORR_PROD_W-1:0] corr_prod;
  logic                              corr_neg;

  logic [muscl_pkg::CORR_W-1:0]       corr_mag;
  logic signed [muscl_pkg::RES_W-1:0] corr_ext, corr_val, centre_ext, res;
  logic signed [muscl_pkg::DATA_W-1:0] face_value_next;
  logic                                saturated_next;

  assign advance       = !result_valid || !result_stall;
  assign request_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= muscl_pkg::EPS_RESET;
    end else if (epsilon_write) begin
      epsilon <= epsilon_data;
    end
  end

  always_comb begin
    diff1_raw = muscl_pkg::CMP_W'(centre_value) - muscl_pkg::CMP_W'(left_value);
    diff2_raw = muscl_pkg::CMP_W'(right_value) - muscl_pkg::CMP_W'(centre_value);
    diff_next.side   = face_side;
    diff_next.centre = centre_value;
    diff_next.d1     = muscl_pkg::clip_diff(diff1_raw);
    diff_next.d2     = muscl_pkg::clip_diff(diff2_raw);
    diff_next.sat    = (diff1_raw > muscl_pkg::D_MAX) || (diff1_raw < muscl_pkg::D_MIN) ||
                       (diff2_raw > muscl_pkg::D_MAX) || (diff2_raw < muscl_pkg::D_MIN);
  end

  always_comb begin
    m1 = muscl_pkg::mag_value(diff_st.d1);
    m2 = muscl_pkg::mag_value(diff_st.d2);
  end

  always_comb begin
    two_p   = muscl_pkg::NUM_W'({prod_12, 1'b0});
    eps_ext = muscl_pkg::NUM_W'(epsilon);
    num_neg_next = 1'b0;
    if (!prod_neg) begin
      num_next = two_p + eps_ext;
    end else if (eps_ext >= two_p) begin
      num_next = eps_ext - two_p;
    end else begin
      num_next     = two_p - eps_ext;
      num_neg_next = 1'b1;
    end
    den_next = muscl_pkg::NUM_W'(prod_11) + muscl_pkg::NUM_W'(prod_22) + eps_ext;
  end

  always_comb begin
    for (int k = 0; k < DS; k++) begin
      div_trial[k]    = (k == 0) ? div_rem[k] : {div_rem[k][muscl_pkg::REM_W-2:0], 1'b0};
      div_ge[k]       = div_trial[k] >= muscl_pkg::REM_W'(div_den[k]);
      div_rem_next[k] = div_ge[k] ? div_trial[k] - muscl_pkg::REM_W'(div_den[k])
                                  : div_trial[k];
      div_q_next[k]   = {div_q[k][muscl_pkg::Q_W-2:0], div_ge[k]};
    end
  end

  assign smag_next = div_zero[DS] ? '0 : div_q[DS];

  always_comb begin
    tmag = muscl_pkg::Q_W'(recip_prod >> muscl_pkg::RECIP_SHIFT);
  end

  always_comb begin
    slope_p = coef_st.side ? coef_st.d1 : coef_st.d2;
    slope_q = coef_st.side ? coef_st.d2 : coef_st.d1;
  end

  always_comb begin
    term_a_mag = muscl_pkg::TERM_W'(scale_pa >> muscl_pkg::FRAC_BITS);
    term_b_mag = muscl_pkg::TERM_W'(scale_qb >> muscl_pkg::FRAC_BITS);
    term_a_abs = signed'(muscl_pkg::MID_W'(term_a_mag));
    term_b_abs = signed'(muscl_pkg::MID_W'(term_b_mag));
    term_a     = scale_pa_neg ? -term_a_abs : term_a_abs;
    term_b     = scale_qb_neg ? -term_b_abs : term_b_abs;
  end

  always_comb begin
    mid_mag = mid_m[muscl_pkg::MID_W-1] ? muscl_pkg::MID_W'(-mid_m)
                                        : muscl_pkg::MID_W'(mid_m);
  end

  always_comb begin
    corr_mag   = muscl_pkg::CORR_W'(corr_prod >> muscl_pkg::CORR_SHIFT);
    corr_ext   = signed'(muscl_pkg::RES_W'(corr_mag));
    corr_val   = corr_neg ? -corr_ext : corr_ext;
    centre_ext = muscl_pkg::RES_W'(corr_st.centre);
    res        = corr_st.side ? centre_ext + corr_val : centre_ext - corr_val;
    saturated_next = corr_st.sat;
    if (res > muscl_pkg::RES_MAX) begin
      face_value_next = muscl_pkg::RES_MAX[muscl_pkg::DATA_W-1:0];
      saturated_next  = 1'b1;
    end else if (res < muscl_pkg::RES_MIN) begin
      face_value_next = muscl_pkg::RES_MIN[muscl_pkg::DATA_W-1:0];
      saturated_next  = 1'b1;
    end else begin
      face_value_next = res[muscl_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid   <= 1'b0;
      prod_valid   <= 1'b0;
      for (int k = 0; k <= DS; k++) begin
        div_valid[k] <= 1'b0;
      end
      recip_valid  <= 1'b0;
      coef_valid   <= 1'b0;
      scale_valid  <= 1'b0;
      mid_valid    <= 1'b0;
      corr_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      diff_valid   <= request_valid;
      prod_valid   <= diff_valid;
      div_valid[0] <= prod_valid;
      for (int k = 0; k < DS; k++) begin
        div_valid[k+1] <= div_valid[k];
      end
      recip_valid  <= div_valid[DS];
      coef_valid   <= recip_valid;
      scale_valid  <= coef_valid;
      mid_valid    <= scale_valid;
      corr_valid   <= mid_valid;
      result_valid <= corr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      diff_st <= diff_next;

      prod_st  <= diff_st;
      prod_12  <= muscl_pkg::PROD_W'(m1) * muscl_pkg::PROD_W'(m2);
      prod_11  <= muscl_pkg::PROD_W'(m1) * muscl_pkg::PROD_W'(m1);
      prod_22  <= muscl_pkg::PROD_W'(m2) * muscl_pkg::PROD_W'(m2);
      prod_neg <= diff_st.d1[VW-1] ^ diff_st.d2[VW-1];

      div_st[0]   <= prod_st;
      div_rem[0]  <= muscl_pkg::REM_W'(num_next);
      div_den[0]  <= den_next;
      div_q[0]    <= '0;
      div_neg[0]  <= num_neg_next;
      div_zero[0] <= (prod_11 == '0) && (prod_22 == '0) && (epsilon == '0);
      for (int k = 0; k < DS; k++) begin
        div_st[k+1]   <= div_st[k];
        div_rem[k+1]  <= div_rem_next[k];
        div_den[k+1]  <= div_den[k];
        div_q[k+1]    <= div_q_next[k];
        div_neg[k+1]  <= div_neg[k];
        div_zero[k+1] <= div_zero[k];
      end

      recip_st   <= div_st[DS];
      recip_prod <= muscl_pkg::RECIP_PROD_W'(smag_next) *
                    muscl_pkg::RECIP_PROD_W'(muscl_pkg::RECIP3);
      recip_smag <= smag_next;
      recip_sneg <= div_neg[DS] && !div_zero[DS];

      coef_st   <= recip_st;
      coef_a    <= recip_sneg ? muscl_pkg::ONE_Q30 + tmag : muscl_pkg::ONE_Q30 - tmag;
      coef_b    <= recip_sneg ? muscl_pkg::ONE_Q30 - tmag : muscl_pkg::ONE_Q30 + tmag;
      coef_smag <= recip_smag;
      coef_sneg <= recip_sneg;

      scale_st     <= coef_st;
      scale_pa     <= muscl_pkg::SCALE_W'(muscl_pkg::mag_value(slope_p)) *
                      muscl_pkg::SCALE_W'(coef_a);
      scale_qb     <= muscl_pkg::SCALE_W'(muscl_pkg::mag_value(slope_q)) *
                      muscl_pkg::SCALE_W'(coef_b);
      scale_pa_neg <= slope_p[VW-1];
      scale_qb_neg <= slope_q[VW-1];
      scale_smag   <= coef_smag;
      scale_sneg   <= coef_sneg;

      mid_st   <= scale_st;
      mid_m    <= term_a + term_b;
      mid_smag <= scale_smag;
      mid_sneg <= scale_sneg;

      corr_st   <= mid_st;
      corr_prod <= muscl_pkg::CORR_PROD_W'(mid_mag) * muscl_pkg::CORR_PROD_W'(mid_smag);
      corr_neg  <= mid_m[muscl_pkg::MID_W-1] != mid_sneg;

      face_value <= face_value_next;
      saturated  <= saturated_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (mid_valid == $past(mid_valid)))
    else $error("pipeline moved while the result was stalled");

  assert property (@(posedge clk) disable iff (rst)
    (div_valid[DS] && !div_zero[DS]) |-> (div_q[DS] <= muscl_pkg::ONE_Q30))
    else $error("smoothness factor above one");

  assert property (@(posedge clk) disable iff (rst)
    (div_valid[DS] && !div_zero[DS]) |->
      (div_rem[DS] < muscl_pkg::REM_W'(div_den[DS])))
    else $error("divider remainder not below denominator");

  assert property (@(posedge clk) disable iff (rst)
    coef_valid |-> ((muscl_pkg::Q_W + 1)'(coef_a) + (muscl_pkg::Q_W + 1)'(coef_b) ==
                    (muscl_pkg::Q_W + 1)'(muscl_pkg::ONE_Q30) << 1))
    else $error("slope weights do not sum to two");

endmodule
